// ===== hw/rtl/timestamp_text_to_ms_parser_macros.svh =====
// assertion macros for the timestamp text to milliseconds parser
`ifndef TIMESTAMP_TEXT_TO_MS_PARSER_MACROS_SVH
`define TIMESTAMP_TEXT_TO_MS_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during rst
`define TSMS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsms assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TSMS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsms assertion failed");

`else

`define TSMS_ASSERT_IMP(name, ante, cons)
`define TSMS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/tsms_pkg.sv =====
// types, constants and scan functions shared by the timestamp parser
`default_nettype none

package tsms_pkg;

  localparam int MAX_LEN = 4096;
  localparam int LEN_W = 12;
  localparam int FIELD_W = 16;
  localparam int FRAC_W = 20;
  localparam int PROD_H_W = 38;
  localparam int PROD_M_W = 32;
  localparam int PROD_S_W = 26;
  localparam int VALUE_W = 49;
  localparam int NUM_FIELDS = 4;

  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'(((MAX_LEN - 1) < 4095) ? (MAX_LEN - 1) : 4095);

  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;
  localparam logic [FIELD_W-1:0] MAX_MIN_SEC = 16'd59;
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] CNT_ONE = 3'd1;
  localparam logic [2:0] CNT_TWO = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_START,
    SCAN_DIGITS,
    SCAN_AFTER,
    SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] fields;
    logic [2:0] idx;
    scan_phase_t phase;
    logic neg;
    logic [7:0] sep;
    logic [LEN_W-1:0] len;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    fields: '0,
    idx: 3'd0,
    phase: SCAN_LEAD,
    neg: 1'b0,
    sep: CH_NUL,
    len: '0
  };

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return c inside {CH_COLON, CH_MINUS, CH_DOT, CH_COMMA};
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [FRAC_W-1:0] times_ten(logic [FIELD_W-1:0] v);
    return {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
  endfunction

  // one character step of the scanner
  function automatic scan_state_t scan_feed(scan_state_t s, logic [7:0] c,
                                            logic [LEN_W-1:0] pos);
    scan_state_t r;
    logic [1:0] slot;
    logic [FRAC_W-1:0] acc;
    logic do_expect;
    logic do_after;
    logic do_close;
    r = s;
    slot = s.idx[1:0];
    acc = times_ten(s.fields[slot]) + {16'b0, c[3:0]};
    do_expect = 1'b0;
    do_after = 1'b0;
    do_close = 1'b0;
    case (s.phase)
      SCAN_LEAD: begin
        if (!is_blank(c)) begin
          r.sep = c;
          r.neg = (c == CH_MINUS);
          r.phase = SCAN_START;
          do_expect = (c != CH_PLUS) && (c != CH_MINUS);
        end
      end
      SCAN_START: do_expect = 1'b1;
      SCAN_DIGITS: begin
        if (is_dig(c)) begin
          r.fields[slot] = (acc > FRAC_W'(FIELD_MAX)) ? FIELD_MAX : acc[FIELD_W-1:0];
          r.len = LEN_W'(pos + 12'd1);
        end else begin
          do_after = 1'b1;
        end
      end
      SCAN_AFTER: do_after = 1'b1;
      default: ;
    endcase
    if (do_expect) begin
      if (is_blank(c)) begin
        r.phase = SCAN_START;
      end else if (is_sep(c)) begin
        r.fields[slot] = '0;
        r.len = pos;
        do_close = 1'b1;
      end else if (is_dig(c)) begin
        r.fields[slot] = {12'b0, c[3:0]};
        r.len = LEN_W'(pos + 12'd1);
        r.phase = SCAN_DIGITS;
      end else begin
        r.phase = SCAN_DONE;
      end
    end
    if (do_after) begin
      if (is_blank(c)) begin
        r.phase = SCAN_AFTER;
      end else if (is_sep(c)) begin
        do_close = 1'b1;
      end else begin
        r.idx = 3'(s.idx + 3'd1);
        r.phase = SCAN_DONE;
      end
    end
    if (do_close) begin
      if (s.idx < CNT_THREE) begin
        r.sep = c;
      end
      r.idx = 3'(s.idx + 3'd1);
      r.phase = (r.idx >= CNT_FOUR) ? SCAN_DONE : SCAN_START;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsms_if.sv =====
// valid/ready channels for input characters and parsed results
`default_nettype none

interface tsms_char_if;
  logic valid;
  logic ready;
  logic [7:0] ch;
  logic last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface tsms_result_if import tsms_pkg::*; ;
  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] value_ms;
  logic invalid;
  logic style;
  logic [LEN_W-1:0] consumed_length;

  modport source (output valid, output value_ms, output invalid, output style,
                  output consumed_length, input ready);
  modport sink (input valid, input value_ms, input invalid, input style,
                input consumed_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tsms_scan.sv =====
// character scanner: field values, separators, sign and length of one string
`default_nettype none
`include "timestamp_text_to_ms_parser_macros.svh"

module tsms_scan import tsms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  ch,
  input  logic        last,
  output scan_state_t fin
);

  scan_state_t st;
  scan_state_t st_next;
  scan_state_t st_char;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] pos_next;
  logic [LEN_W-1:0] pos_inc;

  // next state
  always_comb begin
    st_char = scan_feed(st, ch, pos);
    pos_inc = (pos < LEN_CAP) ? LEN_W'(pos + 12'd1) : pos;
    st_next = st;
    pos_next = pos;
    if (take) begin
      if (last) begin
        st_next = SCAN_RESET;
        pos_next = '0;
      end else begin
        st_next = st_char;
        pos_next = pos_inc;
      end
    end
  end

  // end of string closes the open number
  always_comb begin
    fin = scan_feed(st_char, CH_NUL, pos_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
      pos <= '0;
    end else begin
      st <= st_next;
      pos <= pos_next;
    end
  end

  `TSMS_ASSERT_NXT(a_clear_after_last, take && last, (st.phase == SCAN_LEAD) && (pos == '0) && (st.idx == '0))
  `TSMS_ASSERT_IMP(a_four_fields_done, st.idx == CNT_FOUR, st.phase == SCAN_DONE)
  `TSMS_ASSERT_NXT(a_pos_steps, take && !last && (pos != LEN_CAP), pos == LEN_W'($past(pos) + 12'd1))

endmodule

`default_nettype wire

// ===== hw/rtl/timestamp_text_to_ms_parser.sv =====
// Timestamp text parser top level. Takes one character word per cycle while
// chars.ready is high, with no gaps required; a string ends at the word with
// last set, and once that word is accepted its result word passes the capture,
// multiply and sum stages. Characters of the next string are taken while earlier
// results are still in the pipeline; chars.ready drops only when all three stages
// hold results that results.ready has not yet taken.
`default_nettype none
`include "timestamp_text_to_ms_parser_macros.svh"

module timestamp_text_to_ms_parser import tsms_pkg::*; (
  input logic        clk,
  input logic        rst,
  tsms_char_if.sink     chars,
  tsms_result_if.source results
);

  scan_state_t fin;
  logic take;
  logic en1;
  logic en2;
  logic en3;

  // capture stage
  logic v1;
  scan_state_t s1;

  // multiply stage
  logic v2;
  logic [PROD_H_W-1:0] prod_h;
  logic [PROD_M_W-1:0] prod_m;
  logic [PROD_S_W-1:0] prod_s;
  logic [FRAC_W-1:0] frac2;
  logic ok2;
  logic neg2;
  logic dot2;
  logic [LEN_W-1:0] len2;

  // output stage
  logic v3;
  logic signed [VALUE_W-1:0] value3;
  logic invalid3;
  logic style3;
  logic [LEN_W-1:0] len3;

  logic [FIELD_W-1:0] hour;
  logic [FIELD_W-1:0] minute;
  logic [FIELD_W-1:0] second;
  logic [FRAC_W-1:0] frac;
  logic colon;
  logic dot;
  logic shape_ok;
  logic ok;
  logic [PROD_H_W-1:0] sum;
  logic [VALUE_W-1:0] mag;

  assign en3 = !v3 || results.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign chars.ready = en1;
  assign take = chars.valid && en1;

  tsms_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (chars.ch),
    .last (chars.last),
    .fin  (fin)
  );

  // field roles from count and last separator
  always_comb begin
    colon = (s1.sep == CH_COLON);
    dot = (s1.sep == CH_DOT);
    hour = '0;
    minute = '0;
    second = '0;
    frac = '0;
    shape_ok = 1'b1;
    case (s1.idx)
      CNT_ONE: frac = {4'b0, s1.fields[0]};
      CNT_TWO: begin
        if (colon) begin
          minute = s1.fields[0];
          second = s1.fields[1];
        end else begin
          second = s1.fields[0];
          frac = dot ? times_ten(s1.fields[1]) : {4'b0, s1.fields[1]};
        end
      end
      CNT_THREE: begin
        if (colon) begin
          hour = s1.fields[0];
          minute = s1.fields[1];
          second = s1.fields[2];
        end else begin
          minute = s1.fields[0];
          second = s1.fields[1];
          frac = dot ? times_ten(s1.fields[2]) : {4'b0, s1.fields[2]};
        end
      end
      CNT_FOUR: begin
        hour = s1.fields[0];
        minute = s1.fields[1];
        second = s1.fields[2];
        frac = dot ? times_ten(s1.fields[3]) : {4'b0, s1.fields[3]};
      end
      default: shape_ok = 1'b0;
    endcase
    ok = shape_ok
         && !((hour != '0) && (minute > MAX_MIN_SEC))
         && !(((hour != '0) || (minute != '0)) && (second > MAX_MIN_SEC));
  end

  always_comb begin
    sum = prod_h + PROD_H_W'(prod_m) + PROD_H_W'(prod_s) + PROD_H_W'(frac2);
    mag = VALUE_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= take && chars.last;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= fin;
    end
    if (en2) begin
      prod_h <= PROD_H_W'(hour) * PROD_H_W'(MS_PER_HOUR);
      prod_m <= PROD_M_W'(minute) * PROD_M_W'(MS_PER_MIN);
      prod_s <= PROD_S_W'(second) * PROD_S_W'(MS_PER_SEC);
      frac2 <= frac;
      ok2 <= ok;
      neg2 <= s1.neg;
      dot2 <= dot;
      len2 <= s1.len;
    end
    if (en3) begin
      if (!ok2) begin
        value3 <= '0;
      end else if (neg2) begin
        value3 <= VALUE_W'('0 - mag);
      end else begin
        value3 <= mag;
      end
      invalid3 <= !ok2;
      style3 <= dot2;
      len3 <= len2;
    end
  end

  assign results.valid = v3;
  assign results.value_ms = value3;
  assign results.invalid = invalid3;
  assign results.style = style3;
  assign results.consumed_length = len3;

  `TSMS_ASSERT_IMP(a_invalid_is_zero, v3 && invalid3, value3 == '0)
  `TSMS_ASSERT_NXT(a_last_captured, take && chars.last, v1)
  `TSMS_ASSERT_NXT(a_result_waits, v3 && !results.ready, v3 && $stable(value3))

endmodule

`default_nettype wire

// ===== tb/timestamp_text_to_ms_parser_checker.sv =====
// checker for the timestamp parser: predicts each parsed time from the character words and compares result words
`default_nettype none

module timestamp_text_to_ms_parser_checker import tsms_pkg::*; (
  input logic clk,
  input logic rst,
  tsms_char_if chars,
  tsms_result_if results,
  output int errors,
  output int pending
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_ms;
    logic invalid;
    logic style;
    logic [LEN_W-1:0] consumed_length;
  } parsed_time_t;

  parsed_time_t expected_times[$];
  int fail_count = 0;

  logic [FIELD_W-1:0] field_val [NUM_FIELDS];
  logic [2:0] field_cnt;
  scan_phase_t phase;
  logic minus;
  logic [7:0] last_sep;
  logic [LEN_W-1:0] char_pos;
  logic [LEN_W-1:0] read_len;

  function automatic logic blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic sep_char(logic [7:0] c);
    return c == CH_COLON || c == CH_MINUS || c == CH_DOT || c == CH_COMMA;
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < NUM_FIELDS; i++) field_val[i] = '0;
    field_cnt = '0;
    phase = SCAN_LEAD;
    minus = 1'b0;
    last_sep = CH_NUL;
    char_pos = '0;
    read_len = '0;
  endtask

  task automatic close_field(input logic [7:0] c);
    if (field_cnt < CNT_THREE) last_sep = c;
    field_cnt = field_cnt + 3'd1;
    phase = (field_cnt >= CNT_FOUR) ? SCAN_DONE : SCAN_START;
  endtask

  task automatic begin_field(input logic [7:0] c);
    if (blank_char(c)) begin
      phase = SCAN_START;
    end else if (sep_char(c)) begin
      // empty field reads as zero
      field_val[field_cnt[1:0]] = '0;
      read_len = char_pos;
      close_field(c);
    end else if (digit_char(c)) begin
      field_val[field_cnt[1:0]] = FIELD_W'(c - CH_ZERO);
      read_len = char_pos + 12'd1;
      phase = SCAN_DIGITS;
    end else begin
      phase = SCAN_DONE;
    end
  endtask

  task automatic end_number(input logic [7:0] c);
    if (blank_char(c)) begin
      phase = SCAN_AFTER;
    end else if (sep_char(c)) begin
      close_field(c);
    end else begin
      field_cnt = field_cnt + 3'd1;
      phase = SCAN_DONE;
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    int unsigned acc;
    case (phase)
      SCAN_LEAD: begin
        if (!blank_char(c)) begin
          last_sep = c;
          minus = (c == CH_MINUS);
          phase = SCAN_START;
          if (c != CH_PLUS && c != CH_MINUS) begin_field(c);
        end
      end
      SCAN_START: begin_field(c);
      SCAN_DIGITS: begin
        if (digit_char(c)) begin
          // saturating decimal accumulate
          acc = field_val[field_cnt[1:0]] * 32'd10 + 32'(c - CH_ZERO);
          field_val[field_cnt[1:0]] = (acc > 32'(FIELD_MAX)) ? FIELD_MAX : acc[FIELD_W-1:0];
          read_len = char_pos + 12'd1;
        end else begin
          end_number(c);
        end
      end
      SCAN_AFTER: end_number(c);
      default: ;
    endcase
  endtask

  task automatic finish_timestamp(output parsed_time_t r);
    longint unsigned h, m, s, f, ms;
    longint unsigned t0, t1, t2, t3;
    logic ok, dot, colon;
    t0 = field_val[0];
    t1 = field_val[1];
    t2 = field_val[2];
    t3 = field_val[3];
    dot = (last_sep == CH_DOT);
    colon = (last_sep == CH_COLON);
    h = 0;
    m = 0;
    s = 0;
    f = 0;
    ok = 1'b1;
    case (field_cnt)
      CNT_ONE: f = t0;
      CNT_TWO: begin
        if (colon) begin
          m = t0;
          s = t1;
        end else begin
          s = t0;
          f = dot ? t1 * 10 : t1;
        end
      end
      CNT_THREE: begin
        if (colon) begin
          h = t0;
          m = t1;
          s = t2;
        end else begin
          m = t0;
          s = t1;
          f = dot ? t2 * 10 : t2;
        end
      end
      CNT_FOUR: begin
        h = t0;
        m = t1;
        s = t2;
        f = dot ? t3 * 10 : t3;
      end
      default: ok = 1'b0;
    endcase
    if (h > 0 && m > MAX_MIN_SEC) ok = 1'b0;
    if ((h > 0 || m > 0) && s > MAX_MIN_SEC) ok = 1'b0;
    ms = h * MS_PER_HOUR + m * MS_PER_MIN + s * MS_PER_SEC + f;
    if (!ok) r.value_ms = '0;
    else if (minus) r.value_ms = VALUE_W'(64'd0 - ms);
    else r.value_ms = VALUE_W'(ms);
    r.invalid = !ok;
    r.style = dot;
    r.consumed_length = read_len;
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    parsed_time_t want;
    parsed_time_t got;
    if (rst) begin
      clear_scan();
      expected_times.delete();
    end else begin
      if (results.valid && results.ready) begin
        got.value_ms = results.value_ms;
        got.invalid = results.invalid;
        got.style = results.style;
        got.consumed_length = results.consumed_length;
        if (expected_times.size() == 0) begin
          note_failure($sformatf("result word with no string pending, value_ms %0d",
                                 got.value_ms));
        end else begin
          want = expected_times.pop_front();
          if (got.value_ms !== want.value_ms)
            note_failure($sformatf("value_ms expected %0d got %0d",
                                   want.value_ms, got.value_ms));
          if (got.invalid !== want.invalid)
            note_failure($sformatf("invalid expected %0b got %0b",
                                   want.invalid, got.invalid));
          if (got.style !== want.style)
            note_failure($sformatf("style expected %0b got %0b",
                                   want.style, got.style));
          if (got.consumed_length !== want.consumed_length)
            note_failure($sformatf("consumed_length expected %0d got %0d",
                                   want.consumed_length, got.consumed_length));
        end
      end
      if (chars.valid && chars.ready) begin
        scan_char(chars.ch);
        if (char_pos < LEN_CAP) char_pos = char_pos + 12'd1;
        if (chars.last) begin
          // end of string acts as one more terminating character
          scan_char(CH_NUL);
          finish_timestamp(want);
          expected_times.push_back(want);
          clear_scan();
        end
      end
    end
    errors <= fail_count;
    pending <= expected_times.size();
  end

endmodule

`default_nettype wire

// ===== tb/timestamp_text_to_ms_parser_tb.sv =====
// top of the timestamp parser testbench: clock, reset, character stimulus and verdict
`default_nettype none

module timestamp_text_to_ms_parser_tb import tsms_pkg::*; ;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 950;

  typedef logic [7:0] text_t[$];

  logic clk = 1'b0;
  logic rst;
  bit steady = 1'b0;
  int errors;
  int pending;
  int sent = 0;
  int cycle_count = 0;

  tsms_char_if chars_if ();
  tsms_result_if results_if ();

  timestamp_text_to_ms_parser dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .results(results_if)
  );

  timestamp_text_to_ms_parser_checker checker_i (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .results(results_if),
    .errors(errors),
    .pending(pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (steady) results_if.ready <= 1'b1;
    else results_if.ready <= ($urandom_range(99) >= 21);
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        chars_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    chars_if.last <= l;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(2) == 0) return CH_TAB + 8'($urandom_range(4));
    return CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(3))
      0: return CH_COLON;
      1: return CH_MINUS;
      2: return CH_DOT;
      default: return CH_COMMA;
    endcase
  endfunction

  task automatic make_timestamp(output text_t t);
    int nf;
    int nd;
    int r;
    t = {};
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) t.push_back(pick_blank());
    case ($urandom_range(3))
      0: t.push_back(CH_MINUS);
      1: t.push_back(CH_PLUS);
      default: ;
    endcase
    nf = $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) begin
        if ($urandom_range(7) == 0) t.push_back(pick_blank());
        t.push_back(pick_sep());
        if ($urandom_range(7) == 0) t.push_back(pick_blank());
      end
      r = $urandom_range(99);
      if (r < 5) nd = 0;
      else if (r < 70) nd = $urandom_range(1, 2);
      else if (r < 90) nd = $urandom_range(3, 4);
      else nd = $urandom_range(5, 7);
      repeat (nd) t.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    case ($urandom_range(9))
      0: repeat ($urandom_range(1, 2)) t.push_back(pick_blank());
      1: repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
      default: ;
    endcase
  endtask

  initial begin
    text_t t;
    int start;
    int r;
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.ch <= CH_NUL;
    chars_if.last <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_string("5");
    send_string("  -1:02:03.45");
    send_string("+01:30");
    send_string("12.5");
    send_string("1,250");
    send_string("1:2:3,4");
    send_string("1:60:00");
    send_string("0:0:75");
    send_string("1:75");
    send_string("99999");
    send_string("1:2:3:4:5");
    send_string("::");
    send_string("-");
    send_string("abc");
    send_string("12 : 34");
    send_string("\t\n 5\r");
    send_string("1.2.3.4.");
    send_string("7x9");
    send_string("1-2-3");
    send_string(" +.5");
    send_string("65535:59:59.65535");
    send_string("-65535:59:59,65535");
    send_char(CH_NUL, 1'b0);
    send_string("5");
    send_char("3", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);

    start = sent;
    while (sent - start < RANDOM_CHARS) begin
      steady = (sent - start >= 300) && (sent - start < 600);
      r = $urandom_range(99);
      if (r < 70) begin
        make_timestamp(t);
      end else if (r < 85) begin
        make_timestamp(t);
        if (t.size() > 0) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
      end else begin
        t = {};
        repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(255)));
      end
      send_text(t);
    end
    steady = 1'b0;

    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
